/* hdl/hfpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the hashed function profile counters.
package hfpc_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned RUNS_W  = 32;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned WAYO_W  = 3;

  typedef enum logic {
    CMD_ENTER = 1'b0,
    CMD_EXIT  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DISABLED  = 3'd3,
    ST_ZERO_ADDR = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] func_addr;
    logic [TIME_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [WAYO_W-1:0]  way_used;
    logic [RUNS_W-1:0]  run_count;
    logic [DEPTH_W-1:0] nesting_depth;
    logic [TIME_W-1:0]  total_us;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [RUNS_W-1:0]  runs;
    logic [DEPTH_W-1:0] depth;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  tally;
  } entry_t;

endpackage

/* hdl/hashed_function_profile_counters_top.sv */
`timescale 1ns / 1ps
// Top level of the hashed function profile counters.
//
// Function enter and exit events arrive on the in channel, one result per event
// leaves on the out channel; both use valid and ready. The one-bit cfg channel
// writes the enable register and is always ready; write it only while idle.
// The table holds BUCKETS rows of WAYS entries in one synchronous memory, one
// row per bucket. An event is taken in the idle state: the bucket row is read,
// the matching or first empty way is selected in the select state, and in the
// update state the updated row is written back for an ok status and the result
// is loaded into the output register. A new event is taken only after the
// previous one has left the update state. With BUCKETS not a power of two the
// address is first reduced modulo BUCKETS eight bits per cycle in the hash
// state, before the row is read. After reset a clearing pass writes every row
// to zero, one row per cycle, while no event is taken.
// A result that waits in the output register does not stop the next event
// from being taken; its write-back step waits until the output register frees.
module hashed_function_profile_counters_top #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned WAYS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hfpc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hfpc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import hfpc_pkg::*;

  localparam int unsigned IDX_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          POW2       = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int unsigned HASH_STEPS = ADDR_W / 8;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_SEL   = 5'b01000,
    S_UPD   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0] hsh_q, hsh_d;
  logic             en_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  in_item_t         item_q;

  row_t             bucket_mem [BUCKETS];
  row_t             rd_row_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  row_t             wr_row;

  entry_t           sel_q, sel_d;
  logic [WAY_W-1:0] way_q, way_d;
  logic             hit_q, hit_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;

  entry_t           upd_entry;
  status_e          upd_status;
  logic [TIME_W:0]  tally_sum;
  logic [31:0]      way_wide;
  logic             in_xfer;
  logic             upd_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign upd_go      = (state_q == S_UPD) & (~out_valid_q | out_ready_i);

  always_comb begin
    logic [IDX_W:0] t;
    t = '0;
    rem_d = rem_q;
    hsh_d = hsh_q;
    if (in_xfer) begin
      rem_d = '0;
      hsh_d = in_data_i.func_addr;
    end else if (state_q == S_HASH) begin
      for (int b = 0; b < 8; b++) begin
        t = {rem_d, hsh_d[ADDR_W-1]};
        if (t >= (IDX_W+1)'(BUCKETS)) begin
          t = t - (IDX_W+1)'(BUCKETS);
        end
        rem_d = t[IDX_W-1:0];
        hsh_d = {hsh_d[ADDR_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rem_d;
    if (in_xfer && POW2) begin
      rd_en   = 1'b1;
      rd_addr = in_data_i.func_addr[IDX_W-1:0];
    end else if (state_q == S_HASH && hcnt_q == 3'(HASH_STEPS - 1)) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bucket_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= bucket_mem[rd_addr];
    end
  end

  always_comb begin
    logic [WAYS-1:0] cand;
    for (int w = 0; w < WAYS; w++) begin
      cand[w] = (rd_row_q[w].address == item_q.func_addr) ||
                (item_q.command == CMD_ENTER && rd_row_q[w].address == '0);
    end
    hit_d = 1'b0;
    way_d = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        hit_d = 1'b1;
        way_d = WAY_W'(w);
      end
    end
    sel_d     = rd_row_q[way_d];
    elapsed_d = item_q.timestamp_us - sel_d.start;
  end

  always_comb begin
    upd_entry = sel_q;
    tally_sum = {1'b0, sel_q.tally} + {1'b0, elapsed_q};
    if (item_q.command == CMD_ENTER) begin
      upd_entry.address = item_q.func_addr;
      if (sel_q.runs != '1) begin
        upd_entry.runs = sel_q.runs + RUNS_W'(1);
      end
      if (sel_q.depth != '1) begin
        upd_entry.depth = sel_q.depth + DEPTH_W'(1);
        if (sel_q.depth == '0) begin
          upd_entry.start = item_q.timestamp_us;
        end
      end
    end else begin
      if (sel_q.depth == DEPTH_W'(1)) begin
        upd_entry.tally = tally_sum[TIME_W] ? '1 : tally_sum[TIME_W-1:0];
        upd_entry.start = '0;
      end
      if (sel_q.depth != '0) begin
        upd_entry.depth = sel_q.depth - DEPTH_W'(1);
      end
    end

    if (!en_q) begin
      upd_status = ST_DISABLED;
    end else if (item_q.func_addr == '0) begin
      upd_status = ST_ZERO_ADDR;
    end else if (!hit_q) begin
      upd_status = (item_q.command == CMD_ENTER) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      upd_status = ST_OK;
    end
  end

  assign way_wide = 32'(way_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_row  = '0;
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (upd_go && upd_status == ST_OK) begin
      wr_en   = 1'b1;
      wr_addr = POW2 ? item_q.func_addr[IDX_W-1:0] : rem_q;
      wr_row  = rd_row_q;
      wr_row[way_q] = upd_entry;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    if (upd_go) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.status = upd_status;
      if (upd_status == ST_OK) begin
        out_d.way_used      = way_wide[WAYO_W-1:0];
        out_d.run_count     = upd_entry.runs;
        out_d.nesting_depth = upd_entry.depth;
        out_d.total_us      = upd_entry.tally;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    hcnt_d  = hcnt_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        hcnt_d = '0;
        if (in_xfer) begin
          state_d = POW2 ? S_SEL : S_HASH;
        end
      end
      S_HASH: begin
        hcnt_d = hcnt_q + 3'd1;
        if (hcnt_q == 3'(HASH_STEPS - 1)) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hcnt_q      <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hcnt_q      <= hcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    hsh_q <= hsh_d;
    out_q <= out_d;
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (state_q == S_SEL) begin
      sel_q     <= sel_d;
      way_q     <= way_d;
      hit_q     <= hit_d;
      elapsed_q <= elapsed_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("State register is not one-hot.");

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.way_used == '0 && out_data_o.run_count == '0 &&
      out_data_o.nesting_depth == '0 && out_data_o.total_us == '0)
    else $error("Error result carries nonzero entry fields.");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !upd_go)
    else $error("Event taken during the clearing pass.");

  a_write_gives_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go && wr_en |=> out_valid_o && out_data_o.status == ST_OK)
    else $error("Table write-back without an ok result.");

endmodule
